FILE: src/bit_set_with_size_tracking_unit_macros.svh
// Assertion macros used by the checker file of the bit set unit.
`ifndef BIT_SET_WITH_SIZE_TRACKING_UNIT_MACROS_SVH
`define BIT_SET_WITH_SIZE_TRACKING_UNIT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define BSST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BSST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bsst_pkg.sv
// Types, constants and a helper function of the bit set unit.
`default_nettype none

package bsst_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned WORD_AW      = $clog2(WORD_BITS);
  localparam int unsigned OUT_CNT_W    = 11;

  localparam logic [2:0] CMD_SET       = 3'd0;
  localparam logic [2:0] CMD_CLEAR     = 3'd1;
  localparam logic [2:0] CMD_FLIP      = 3'd2;
  localparam logic [2:0] CMD_READ      = 3'd3;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] bit_index;
  } in_item_t;

  typedef struct packed {
    logic                 bit_value;
    logic [OUT_CNT_W-1:0] set_size;
    logic [OUT_CNT_W-1:0] ones_count;
    logic                 index_error;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_MODIFY = 4'b0100,
    ST_SCAN   = 4'b1000
  } state_e;

  // Position of the highest set bit, binary search over halves.
  function automatic logic [WORD_AW-1:0] find_last_set(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [WORD_AW-1:0]   pos;
    v   = w;
    pos = '0;
    for (int s = WORD_AW - 1; s >= 0; s--) begin
      if ((v >> (1 << s)) != '0) begin
        pos[s] = 1'b1;
        v      = v >> (1 << s);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

FILE: src/bsst_word_mem.sv
// Word memory of the bit set: one write port, one registered read port.
`default_nettype none

module bsst_word_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 32
) (
  input  wire logic              clk_i,
  input  bsst_pkg::mem_ctl_t     ctl_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DW-1:0]     wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DW-1:0]     rdata_o
);
  import bsst_pkg::*;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/bsst_seq.sv
// Sequencer of the bit set: read-modify-write, shrink scan, clearing pass.
`default_nettype none

module bsst_seq #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned NUM_WORDS = 32,
  parameter int unsigned WA        = 5,
  parameter int unsigned SIZE_W    = 11
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  bsst_pkg::in_item_t                 in_item_i,
  output logic                               in_stall_o,
  output bsst_pkg::mem_ctl_t                 mem_ctl_o,
  output logic [WA-1:0]                      mem_waddr_o,
  output logic [bsst_pkg::WORD_BITS-1:0]     mem_wdata_o,
  output logic [WA-1:0]                      mem_raddr_o,
  input  wire logic [bsst_pkg::WORD_BITS-1:0] mem_rdata_i,
  input  wire logic                          res_ready_i,
  output logic                               res_valid_o,
  output bsst_pkg::out_item_t                res_o
);
  import bsst_pkg::*;

  localparam logic [WA-1:0] LAST_ADDR = WA'(NUM_WORDS - 1);

  state_e            state_q, state_d;
  logic [2:0]        cmd_q;
  logic [15:0]       idx_q;
  logic              err_q;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] ones_q, ones_d;
  logic [WA-1:0]     scan_q, scan_d;
  logic [WA-1:0]     clr_q, clr_d;
  logic              reply_q, reply_d;

  logic              accept;
  logic              in_err;
  logic [15:0]       in_word;
  logic [WA-1:0]     in_addr;
  logic [15:0]       cur_word;
  logic [WA-1:0]     cur_addr;
  logic [WORD_AW-1:0] bit_pos;
  logic              old_bit, new_bit;
  logic [WORD_BITS-1:0] new_word;
  logic [SIZE_W-1:0] idx_p1;
  logic              shrink;
  logic              res_bit, res_err;
  logic [31:0]       size_ext, ones_ext;

  function automatic logic [SIZE_W-1:0] top_size(input logic [WA-1:0] addr,
                                                 input logic [WORD_AW-1:0] pos);
    return SIZE_W'((32'(addr) << WORD_AW) + 32'(pos) + 32'd1);
  endfunction

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_err   = {1'b0, in_item_i.bit_index} >= 17'(CAPACITY);
  assign in_word  = in_item_i.bit_index >> WORD_AW;
  assign in_addr  = in_word[WA-1:0];
  assign cur_word = idx_q >> WORD_AW;
  assign cur_addr = cur_word[WA-1:0];
  assign bit_pos  = idx_q[WORD_AW-1:0];
  assign old_bit  = mem_rdata_i[bit_pos];
  assign idx_p1   = SIZE_W'(32'(idx_q) + 32'd1);

  always_comb begin
    unique case (cmd_q)
      CMD_SET:   new_bit = 1'b1;
      CMD_CLEAR: new_bit = 1'b0;
      CMD_FLIP:  new_bit = ~old_bit;
      default:   new_bit = old_bit;
    endcase
    new_word          = mem_rdata_i;
    new_word[bit_pos] = new_bit;
  end

  // top bit going away
  assign shrink = old_bit && !new_bit && (idx_p1 == size_q);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    ones_d      = ones_q;
    scan_d      = scan_q;
    clr_d       = clr_q;
    reply_d     = reply_q;
    mem_ctl_o   = '0;
    mem_waddr_o = cur_addr;
    mem_wdata_o = new_word;
    mem_raddr_o = in_addr;
    res_valid_o = 1'b0;
    res_bit     = 1'b0;
    res_err     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = clr_q;
        mem_wdata_o     = '0;
        if (clr_q == LAST_ADDR) begin
          if (!reply_q) begin
            state_d = ST_IDLE;
          end else if (res_ready_i) begin
            res_valid_o = 1'b1;
            reply_d     = 1'b0;
            state_d     = ST_IDLE;
          end
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.command == CMD_CLEAR_ALL) begin
            state_d = ST_CLEAR;
            clr_d   = '0;
            reply_d = 1'b1;
            size_d  = '0;
            ones_d  = '0;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
            state_d         = ST_MODIFY;
          end
        end
      end
      ST_MODIFY: begin
        if (err_q) begin
          if (res_ready_i) begin
            res_valid_o = 1'b1;
            res_err     = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (shrink && (new_word == '0) && (cur_addr != '0)) begin
          // no lower bit in this word: walk down the lower words
          mem_ctl_o.wr_en = 1'b1;
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = cur_addr - 1'b1;
          scan_d          = cur_addr - 1'b1;
          ones_d          = ones_q - 1'b1;
          state_d         = ST_SCAN;
        end else if (res_ready_i) begin
          mem_ctl_o.wr_en = old_bit != new_bit;
          if (new_bit && !old_bit) begin
            ones_d = ones_q + 1'b1;
          end else if (old_bit && !new_bit) begin
            ones_d = ones_q - 1'b1;
          end
          if (new_bit && (size_q < idx_p1)) begin
            size_d = idx_p1;
          end else if (shrink) begin
            size_d = (new_word != '0) ? top_size(cur_addr, find_last_set(new_word)) : '0;
          end
          res_valid_o = 1'b1;
          res_bit     = new_bit;
          state_d     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if ((mem_rdata_i != '0) || (scan_q == '0)) begin
          if (res_ready_i) begin
            size_d = (mem_rdata_i != '0) ? top_size(scan_q, find_last_set(mem_rdata_i))
                                         : '0;
            res_valid_o = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = scan_q - 1'b1;
          scan_d          = scan_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign size_ext = 32'(size_d);
  assign ones_ext = 32'(ones_d);

  always_comb begin
    res_o.bit_value   = res_bit;
    res_o.set_size    = size_ext[OUT_CNT_W-1:0];
    res_o.ones_count  = ones_ext[OUT_CNT_W-1:0];
    res_o.index_error = res_err;
  end

  assign in_stall_o = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      size_q  <= '0;
      ones_q  <= '0;
      scan_q  <= '0;
      clr_q   <= '0;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      ones_q  <= ones_d;
      scan_q  <= scan_d;
      clr_q   <= clr_d;
      reply_q <= reply_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_item_i.command;
      idx_q <= in_item_i.bit_index;
      err_q <= in_err;
    end
  end

endmodule

`default_nettype wire

FILE: src/bsst_out_reg.sv
// Output register of the bit set: holds one result until it is taken.
`default_nettype none

module bsst_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  bsst_pkg::out_item_t item_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output bsst_pkg::out_item_t out_item_o
);
  import bsst_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

FILE: src/bit_set_with_size_tracking_unit.sv
// Top level of the bit set unit with size and set-bit count tracking.
// The bits live in one word memory of ceil(CAPACITY/32) words of 32 bits with a registered
// read port; every request other than clear all first reads its word, and set, clear and
// flip write it back when the bit changes. Clearing the highest set bit when no lower bit
// is left in its word then reads the lower words one by one until a set bit or word 0 is
// found. Clear all is accepted in ST_IDLE and then sweeps the memory one word a cycle; the
// same sweep runs after reset, with in_stall_o high while it runs. One request is worked on
// at a time; a finished result sits in an output register while the next request is taken,
// and a request whose result finds that register still stalled waits until it drains.
// set_size and ones_count show the low 11 bits of the tracked values.
`default_nettype none

module bit_set_with_size_tracking_unit #(
  parameter int unsigned CAPACITY = bsst_pkg::CAPACITY_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  bsst_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output bsst_pkg::out_item_t out_item_o
);
  import bsst_pkg::*;

  localparam int unsigned NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned SIZE_W    = $clog2(CAPACITY + 1);

  mem_ctl_t             mem_ctl;
  logic [WA-1:0]        mem_waddr;
  logic [WA-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 res_ready;
  logic                 res_valid;
  out_item_t            res;

  bsst_word_mem #(
    .DEPTH (NUM_WORDS),
    .AW    (WA),
    .DW    (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bsst_seq #(
    .CAPACITY  (CAPACITY),
    .NUM_WORDS (NUM_WORDS),
    .WA        (WA),
    .SIZE_W    (SIZE_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bsst_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .item_i      (res),
    .ready_o     (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: src/bsst_checker.sv
// Port-level checks of the bit set unit and their bind to the top level.
`default_nettype none
`include "bit_set_with_size_tracking_unit_macros.svh"

module bsst_checker #(
  parameter int unsigned CAPACITY = bsst_pkg::CAPACITY_DEF
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_i,
  input wire logic           out_valid_i,
  input wire logic           out_stall_i,
  input bsst_pkg::out_item_t out_item_i
);
  import bsst_pkg::*;

  // counts are only comparable while they fit the output fields
  localparam bit CNT_EXACT = CAPACITY < (1 << OUT_CNT_W);

  `BSST_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i), "stalled result changed")
  `BSST_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_i |=> in_stall_i, "request taken while another is in work")
  `BSST_ASSERT_ALWAYS(a_err_bit_zero, clk_i, out_valid_i && out_item_i.index_error |-> !out_item_i.bit_value, "bit value set on index error")
  `BSST_ASSERT(a_count_le_size, clk_i, rst_ni, CNT_EXACT && out_valid_i |-> out_item_i.ones_count <= out_item_i.set_size, "count above size")
  `BSST_ASSERT(a_set_bit_nonempty, clk_i, rst_ni, CNT_EXACT && out_valid_i && out_item_i.bit_value |-> (out_item_i.ones_count != '0) && (out_item_i.set_size != '0), "set bit reported in empty set")

endmodule

bind bit_set_with_size_tracking_unit bsst_checker #(
  .CAPACITY (CAPACITY)
) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire
